[design/byte_ring_fifo_overwrite_defines.svh]
// Assertion macros for the byte ring FIFO block.
// Included by the RTL files that carry concurrent assertions.
`ifndef BYTE_RING_FIFO_OVERWRITE_DEFINES_SVH
`define BYTE_RING_FIFO_OVERWRITE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge outside reset.
`define BRFO_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("brfo: invariant violated");
// A consequence that holds in the same cycle as its antecedent.
`define BRFO_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brfo: same-cycle implication violated");
// A consequence that holds in the cycle after its antecedent.
`define BRFO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brfo: next-cycle implication violated");
`else
`define BRFO_ASSERT_ALWAYS(label, clk, rst, expr)
`define BRFO_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BRFO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/brfo_pkg.sv]
// Shared constants, command codes and types of the byte ring FIFO.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brfo_pkg;

   localparam int STORE_DEPTH = 256;
   localparam int IDX_W       = $clog2(STORE_DEPTH);
   localparam int SIZE_W      = 9;
   localparam int CMD_W       = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [SIZE_W-1:0] size_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;   // capture the request payload
      logic exec;    // run the FIFO update and memory access
      logic load;    // load the result register
   } brfo_cmd_type;

endpackage

`default_nettype wire

[design/brfo_if.sv]
// Handshake channel interfaces of the byte ring FIFO: request, response and
// size register write. Depends on brfo_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface brfo_req_if;
   import brfo_pkg::*;
   logic    valid;
   logic    ready;
   cmd_type cmd;
   logic [7:0] data_in;
   logic    force_req;
   logic    has_data;
   logic    last_in_call;

   modport source (output valid, cmd, data_in, force_req, has_data, last_in_call,
                   input ready);
   modport sink   (input valid, cmd, data_in, force_req, has_data, last_in_call,
                   output ready);
endinterface

interface brfo_rsp_if;
   import brfo_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic       accepted;
   size_type   call_total;
   size_type   fill_level;
   size_type   free_space;
   logic       is_empty;
   logic       is_full;
   size_type   read_run;
   size_type   write_run;
   size_type   write_run_forced;

   modport source (output valid, data_out, accepted, call_total, fill_level,
                   free_space, is_empty, is_full, read_run, write_run,
                   write_run_forced,
                   input ready);
   modport sink   (input valid, data_out, accepted, call_total, fill_level,
                   free_space, is_empty, is_full, read_run, write_run,
                   write_run_forced,
                   output ready);
endinterface

interface brfo_csr_if;
   import brfo_pkg::*;
   logic     valid;
   logic     ready;
   size_type buffer_size;

   modport source (output valid, buffer_size, input ready);
   modport sink   (input valid, buffer_size, output ready);
endinterface

`default_nettype wire

[design/brfo_ctrl.sv]
// Sequencing controller of the byte ring FIFO: accept, execute, load result.
// Depends on brfo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brfo_ctrl
   import brfo_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output      logic   req_ready,
   input  wire logic   rsp_ready,
   output      logic   rsp_valid,
   output brfo_cmd_type dp_cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_STAT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The result register may be reloaded once its item is gone or leaves now.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assign dp_cmd.latch = req_valid && req_ready;
   assign dp_cmd.exec  = (state_ff == S_EXEC);
   assign dp_cmd.load  = (state_ff == S_STAT) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_STAT;
         end
         S_STAT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/brfo_datapath.sv]
// Datapath of the byte ring FIFO: byte store, indices with lap bits, call
// counter, size register and result register. Depends on brfo_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "byte_ring_fifo_overwrite_defines.svh"

module brfo_datapath
   import brfo_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire brfo_cmd_type dp_cmd,
   input  wire cmd_type      req_cmd,
   input  wire logic [7:0]   req_data_in,
   input  wire logic         req_force_req,
   input  wire logic         req_has_data,
   input  wire logic         req_last_in_call,
   input  wire logic         csr_write,
   input  wire size_type     csr_buffer_size,
   output      logic [7:0]   rsp_data_out,
   output      logic         rsp_accepted,
   output      size_type     rsp_call_total,
   output      size_type     rsp_fill_level,
   output      size_type     rsp_free_space,
   output      logic         rsp_is_empty,
   output      logic         rsp_is_full,
   output      size_type     rsp_read_run,
   output      size_type     rsp_write_run,
   output      size_type     rsp_write_run_forced
);

   function automatic size_type fill_of(idx_type wi, logic wl, idx_type ri, logic rl,
                                        size_type sz);
      size_type f;
      if (wi == ri) begin
         f = (wl == rl) ? '0 : sz;
      end else if (wi > ri) begin
         f = {1'b0, wi} - {1'b0, ri};
      end else begin
         f = sz - ({1'b0, ri} - {1'b0, wi});
      end
      return f;
   endfunction

   function automatic size_type min_of(size_type a, size_type b);
      return (a < b) ? a : b;
   endfunction

   logic [7:0] store [STORE_DEPTH];

   // Request payload
   cmd_type    cmd_ff;
   logic [7:0] din_ff;
   logic       force_ff, has_ff, last_ff;

   // FIFO control state
   size_type sz_ff;
   idx_type  wr_idx_ff, wr_idx_in, rd_idx_ff, rd_idx_in;
   logic     wr_lap_ff, wr_lap_in, rd_lap_ff, rd_lap_in;
   size_type call_cnt_ff, call_cnt_in;

   // Per-item results of the execute step
   logic       acc_ff, acc_in;
   logic       rd_hit_ff, rd_hit_in;
   size_type   total_ff, total_in;
   logic [7:0] rdata_ff;
   logic       mem_we;

   size_type fill_now, cnt_step, wr_inc, rd_inc, size_clamped;
   logic     has_room, wr_wrap, rd_wrap;

   size_type fill_st, free_st, rd_lim, wr_lim;

   always_comb begin
      if (csr_buffer_size == '0) begin
         size_clamped = size_type'(1);
      end else if (csr_buffer_size > size_type'(STORE_DEPTH)) begin
         size_clamped = size_type'(STORE_DEPTH);
      end else begin
         size_clamped = csr_buffer_size;
      end
   end

   // Execute step: one FIFO access against the state left by the last item.
   always_comb begin
      fill_now = fill_of(wr_idx_ff, wr_lap_ff, rd_idx_ff, rd_lap_ff, sz_ff);
      has_room = fill_now < sz_ff;
      wr_inc   = {1'b0, wr_idx_ff} + size_type'(1);
      rd_inc   = {1'b0, rd_idx_ff} + size_type'(1);
      wr_wrap  = wr_inc >= sz_ff;
      rd_wrap  = rd_inc >= sz_ff;

      wr_idx_in = wr_idx_ff;
      wr_lap_in = wr_lap_ff;
      rd_idx_in = rd_idx_ff;
      rd_lap_in = rd_lap_ff;
      acc_in    = 1'b0;
      rd_hit_in = 1'b0;
      mem_we    = 1'b0;
      total_in  = '0;
      cnt_step  = call_cnt_ff;
      call_cnt_in = call_cnt_ff;

      case (cmd_ff)
         CMD_WRITE: begin
            if (has_room || force_ff) begin
               acc_in    = 1'b1;
               mem_we    = has_ff;
               wr_idx_in = wr_wrap ? '0 : wr_inc[IDX_W-1:0];
               wr_lap_in = wr_lap_ff ^ wr_wrap;
               // A forced write into a full FIFO drops the oldest byte.
               if (!has_room) begin
                  rd_idx_in = rd_wrap ? '0 : rd_inc[IDX_W-1:0];
                  rd_lap_in = rd_lap_ff ^ rd_wrap;
               end
            end
         end
         CMD_READ: begin
            if (fill_now != '0) begin
               acc_in    = 1'b1;
               rd_hit_in = 1'b1;
               rd_idx_in = rd_wrap ? '0 : rd_inc[IDX_W-1:0];
               rd_lap_in = rd_lap_ff ^ rd_wrap;
            end
         end
         CMD_CLEAR: begin
            wr_idx_in   = '0;
            wr_lap_in   = 1'b0;
            rd_idx_in   = '0;
            rd_lap_in   = 1'b0;
            call_cnt_in = '0;
         end
         default: begin
         end
      endcase

      // Rejected accesses still close a call when they carry the last flag.
      if (cmd_ff inside {CMD_WRITE, CMD_READ}) begin
         if (acc_in && (call_cnt_ff < sz_ff)) cnt_step = call_cnt_ff + size_type'(1);
         if (last_ff) begin
            total_in    = cnt_step;
            call_cnt_in = '0;
         end else begin
            call_cnt_in = cnt_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.latch) begin
         cmd_ff   <= req_cmd;
         din_ff   <= req_data_in;
         force_ff <= req_force_req;
         has_ff   <= req_has_data;
         last_ff  <= req_last_in_call;
      end
      if (dp_cmd.exec) begin
         acc_ff    <= acc_in;
         rd_hit_ff <= rd_hit_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec && mem_we) store[wr_idx_ff] <= din_ff;
      if (dp_cmd.exec) rdata_ff <= store[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sz_ff       <= size_type'(STORE_DEPTH);
         wr_idx_ff   <= '0;
         wr_lap_ff   <= 1'b0;
         rd_idx_ff   <= '0;
         rd_lap_ff   <= 1'b0;
         call_cnt_ff <= '0;
      end else if (csr_write) begin
         // A new size always starts from an empty FIFO.
         sz_ff       <= size_clamped;
         wr_idx_ff   <= '0;
         wr_lap_ff   <= 1'b0;
         rd_idx_ff   <= '0;
         rd_lap_ff   <= 1'b0;
         call_cnt_ff <= '0;
      end else if (dp_cmd.exec) begin
         wr_idx_ff   <= wr_idx_in;
         wr_lap_ff   <= wr_lap_in;
         rd_idx_ff   <= rd_idx_in;
         rd_lap_ff   <= rd_lap_in;
         call_cnt_ff <= call_cnt_in;
      end
   end

   // Status step: fill and run lengths after the item.
   always_comb begin
      fill_st = fill_of(wr_idx_ff, wr_lap_ff, rd_idx_ff, rd_lap_ff, sz_ff);
      free_st = sz_ff - fill_st;
      rd_lim  = sz_ff - {1'b0, rd_idx_ff};
      wr_lim  = sz_ff - {1'b0, wr_idx_ff};
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         rsp_data_out         <= rd_hit_ff ? rdata_ff : 8'd0;
         rsp_accepted         <= acc_ff;
         rsp_call_total       <= total_ff;
         rsp_fill_level       <= fill_st;
         rsp_free_space       <= free_st;
         rsp_is_empty         <= (fill_st == '0);
         rsp_is_full          <= (fill_st == sz_ff);
         rsp_read_run         <= (fill_st == '0) ? '0 : min_of(fill_st, rd_lim);
         rsp_write_run        <= (free_st == '0) ? '0 : min_of(free_st, wr_lim);
         rsp_write_run_forced <= wr_lim;
      end
   end

`BRFO_ASSERT_ALWAYS(a_idx_in_range, clock, reset, ({1'b0, wr_idx_ff} < sz_ff) && ({1'b0, rd_idx_ff} < sz_ff))
`BRFO_ASSERT_IMPLY(a_count_bounded, clock, reset, dp_cmd.exec, call_cnt_ff <= sz_ff)
`BRFO_ASSERT_NEXT(a_fill_free_sum, clock, reset, dp_cmd.load, ({1'b0, rsp_fill_level} + {1'b0, rsp_free_space}) == {1'b0, sz_ff})
`BRFO_ASSERT_NEXT(a_clear_empties, clock, reset, dp_cmd.exec && !csr_write && (cmd_ff == CMD_CLEAR), (wr_idx_ff == '0) && (rd_idx_ff == '0) && (call_cnt_ff == '0))

endmodule

`default_nettype wire

[design/byte_ring_fifo_overwrite.sv]
// Top level of the byte ring FIFO with overwrite: controller plus datapath.
// Depends on brfo_pkg, brfo_if, brfo_ctrl and brfo_datapath.
//
//   Channel   Role    Carries
//   req_chan  sink    cmd, data_in, force_req, has_data, last_in_call
//   rsp_chan  source  data_out, accepted, call_total, fill and run status
//   csr_chan  sink    buffer_size (write only, always ready)
//
// Each item passes through accept, execute (store access and index update),
// status; the result is registered and shown the cycle after the status step.
// A new item is accepted only once the last one has left the status step.
// An item is accepted while the previous result still waits on rsp_chan; the
// status step holds until the result register is free.
// Reset clears indices, lap bits, call count and sets the size to 256; the
// byte store is not cleared, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_overwrite
   import brfo_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   brfo_req_if.sink     req_chan,
   brfo_rsp_if.source   rsp_chan,
   brfo_csr_if.sink     csr_chan
);

   brfo_cmd_type dp_cmd;
   logic         req_ready;
   logic         rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign csr_chan.ready = 1'b1;

   brfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd)
   );

   brfo_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .dp_cmd               (dp_cmd),
      .req_cmd              (req_chan.cmd),
      .req_data_in          (req_chan.data_in),
      .req_force_req        (req_chan.force_req),
      .req_has_data         (req_chan.has_data),
      .req_last_in_call     (req_chan.last_in_call),
      .csr_write            (csr_chan.valid),
      .csr_buffer_size      (csr_chan.buffer_size),
      .rsp_data_out         (rsp_chan.data_out),
      .rsp_accepted         (rsp_chan.accepted),
      .rsp_call_total       (rsp_chan.call_total),
      .rsp_fill_level       (rsp_chan.fill_level),
      .rsp_free_space       (rsp_chan.free_space),
      .rsp_is_empty         (rsp_chan.is_empty),
      .rsp_is_full          (rsp_chan.is_full),
      .rsp_read_run         (rsp_chan.read_run),
      .rsp_write_run        (rsp_chan.write_run),
      .rsp_write_run_forced (rsp_chan.write_run_forced)
   );

endmodule

`default_nettype wire
